// ----- design/opdc_pkg.sv -----
// Package with shared types, constants and the PID scaling function.
package opdc_pkg;

    localparam int MAX_TRACKED_DEF = 16;
    localparam int VAL_W = 40;
    localparam int STAMP_W = 32;
    // ceil(2^39 / 255); exact floor division by 255 for dividends below 2^25.
    localparam logic [31:0] RECIP255 = 32'd2155905153;
    localparam int RECIP255_SH = 39;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_FULL    = 3'd2,
        ST_HIT     = 3'd3,
        ST_MISS    = 3'd4
    } status_t;

    // Request as classified by the front end.
    typedef struct packed {
        logic                     lookup;
        logic [7:0]               pid;
        logic                     known;
        logic signed [VAL_W-1:0]  value;
        logic [STAMP_W-1:0]       stamp;
    } req_t;

    // A*100000/255 rounded, for A in 0..255: floor((A*100000 + 127) / 255)
    // by reciprocal multiplication.
    function automatic logic signed [VAL_W-1:0] pct255(input logic [7:0] a);
        logic [24:0] y;
        logic [56:0] p;
        logic [17:0] q;
        begin
            y = 25'(a) * 25'd100000 + 25'd127;
            p = 57'(y) * 57'(RECIP255);
            q = p[56:RECIP255_SH];
            pct255 = VAL_W'(signed'({1'b0, q}));
        end
    endfunction

    // Decode one response into thousandths; known flags a supported PID.
    function automatic logic [VAL_W:0] decode(input logic [7:0] pid,
            input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
            input logic [7:0] d);
        logic signed [VAL_W-1:0] sa;
        logic signed [VAL_W-1:0] sw;
        logic signed [VAL_W-1:0] sw2;
        logic signed [VAL_W-1:0] v;
        logic                    k;
        begin
            sa  = VAL_W'(signed'({1'b0, a}));
            sw  = VAL_W'(signed'({1'b0, a, b}));
            sw2 = VAL_W'(signed'({1'b0, b, c}));
            k = 1'b1;
            v = '0;
            case (pid)
                8'h04, 8'h11, 8'h2C, 8'h2F, 8'h47, 8'h49, 8'h4A, 8'h52:
                    v = pct255(a);
                8'h05, 8'h0F, 8'h46, 8'h5C: v = (sa - 40) * 1000;
                // (A-128)*100000/128 = (A-128)*781.25, rounded half up.
                8'h06, 8'h07, 8'h08, 8'h09: v = ((sa - 128) * 3125 + 2) >>> 2;
                8'h0A: v = sa * 3000;
                8'h0B, 8'h0D, 8'h1C, 8'h33, 8'h51: v = sa * 1000;
                8'h0C: v = sw * 250;
                8'h0E: v = sa * 500 - 64000;
                8'h10: v = sw * 10;
                8'h14: v = sa * 5;
                8'h1F, 8'h63: v = sw * 1000;
                8'h23, 8'h74: v = sw * 10000;
                8'h3C: v = sw * 100 - 40000;
                8'h42: v = sw;
                8'h5D: v = ((sw - 26880) * 125 + 8) >>> 4;
                8'h5E: v = sw * 50;
                8'h61, 8'h62: v = (sa - 125) * 1000;
                8'h6F, 8'h70: v = ((sw * 125 + 2) >>> 2) - 1000;
                8'h78: v = sw2 * 100 - 40000;
                8'hA6: v = VAL_W'(signed'({1'b0, a, b, c, d})) * 100;
                default: k = 1'b0;
            endcase
            decode = {k, v};
        end
    endfunction

endpackage

// ----- design/opdc_front.sv -----
// Front end: accepts requests, decodes the response and queues it.
module opdc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [7:0]        pid,
    input  logic [31:0]       bytes_abcd,
    input  logic [31:0]       now_ms,
    output logic              q_valid,
    input  logic              q_ready,
    output opdc_pkg::req_t    q_req
);
    localparam int QD = 2;
    opdc_pkg::req_t mem_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [opdc_pkg::VAL_W:0] dec;
    opdc_pkg::req_t r;
    logic push, pop;

    always_comb begin
        dec = opdc_pkg::decode(pid, bytes_abcd[7:0], bytes_abcd[15:8],
                               bytes_abcd[23:16], bytes_abcd[31:24]);
        r.lookup = action;
        r.pid = pid;
        r.known = dec[opdc_pkg::VAL_W];
        r.value = dec[opdc_pkg::VAL_W-1:0];
        r.stamp = now_ms;
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_req = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= r;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- design/opdc_back.sv -----
// Back end: searches and updates the PID cache, holds the result register.
module opdc_back #(
    parameter int MAX_TRACKED = opdc_pkg::MAX_TRACKED_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  opdc_pkg::req_t                    q_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        out_status,
    output logic signed [opdc_pkg::VAL_W-1:0] out_value,
    output logic [opdc_pkg::STAMP_W-1:0]      out_stamp
);
    localparam int IW = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
    localparam int CW = $clog2(MAX_TRACKED + 1);

    logic [7:0]                        pid_reg   [MAX_TRACKED];
    logic signed [opdc_pkg::VAL_W-1:0] value_reg [MAX_TRACKED];
    logic [opdc_pkg::STAMP_W-1:0]      stamp_reg [MAX_TRACKED];
    logic [CW-1:0] count_reg;
    logic          hit;
    logic [IW-1:0] idx;
    logic          do_req, wr, alloc;
    opdc_pkg::status_t st;
    logic [IW-1:0] widx;
    logic signed [opdc_pkg::VAL_W-1:0] out_value_next;
    logic [opdc_pkg::STAMP_W-1:0]      out_stamp_next;

    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = MAX_TRACKED - 1; i >= 0; i--) begin
            if (CW'(i) < count_reg && pid_reg[i] == q_req.pid) begin
                hit = 1'b1;
                idx = IW'(i);
            end
        end
    end

    assign q_ready = !out_valid || out_ready;
    assign do_req = q_valid && q_ready;

    always_comb begin
        alloc = 1'b0;
        wr = 1'b0;
        widx = hit ? idx : count_reg[IW-1:0];
        if (q_req.lookup) begin
            st = hit ? opdc_pkg::ST_HIT : opdc_pkg::ST_MISS;
        end else if (!q_req.known) begin
            st = opdc_pkg::ST_UNKNOWN;
        end else if (hit) begin
            st = opdc_pkg::ST_STORED;
            wr = 1'b1;
        end else if (count_reg < CW'(MAX_TRACKED)) begin
            st = opdc_pkg::ST_STORED;
            wr = 1'b1;
            alloc = 1'b1;
        end else begin
            st = opdc_pkg::ST_FULL;
        end
    end

    always_comb begin
        out_value_next = '0;
        out_stamp_next = '0;
        if (q_req.lookup && hit) begin
            out_value_next = value_reg[idx];
            out_stamp_next = stamp_reg[idx];
        end else if (!q_req.lookup && q_req.known) begin
            out_value_next = q_req.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_req) begin
            out_status <= 3'(st);
            out_value <= out_value_next;
            out_stamp <= out_stamp_next;
            if (wr) begin
                pid_reg[widx] <= q_req.pid;
                value_reg[widx] <= q_req.value;
                stamp_reg[widx] <= q_req.stamp;
            end
        end
        if (!aresetn) begin
            out_valid <= 1'b0;
            count_reg <= '0;
        end else begin
            if (do_req) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
            if (do_req && alloc) count_reg <= count_reg + 1'b1;
        end
    end
endmodule

// ----- design/obd2_pid_decode_and_cache_unit.sv -----
// Top level of the OBD-II PID decoder with its PID-keyed value cache.
//
// Input stream s_axis: one request per transfer. tuser carries action
// (0 decode and store, 1 look up); tdata carries pid, bytes A to D and
// now_ms. Output stream m_axis: one result per request, tdata carrying
// status, value_milli and stamp_ms.
// The front end decodes the response with the PID's scaling formula and
// places it in a two-entry queue; the back end compares the PID against
// all cache entries in parallel, updates the cache and loads the output
// register. A request is written into the queue register and then into the
// output register, where m_axis_tvalid rises; one request per cycle is
// sustained while the receiver takes results.
// When the receiver stalls, the output register holds its result, the
// queue fills and s_axis_tready falls once two requests wait.
// Reset empties the queue, drops the output and marks the cache empty;
// no clearing pass is needed.
module obd2_pid_decode_and_cache_unit #(
    parameter int MAX_TRACKED = opdc_pkg::MAX_TRACKED_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // pid, byte_a, byte_b, byte_c, byte_d, now_ms
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // status, value_milli, stamp_ms, zero pad
);
    logic q_valid, q_ready;
    opdc_pkg::req_t q_req;
    logic [2:0] st;
    logic signed [opdc_pkg::VAL_W-1:0] val;
    logic [opdc_pkg::STAMP_W-1:0] stp;

    opdc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tuser), .pid(s_axis_tdata[7:0]),
        .bytes_abcd(s_axis_tdata[39:8]), .now_ms(s_axis_tdata[71:40]),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    opdc_back #(.MAX_TRACKED(MAX_TRACKED)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(st), .out_value(val), .out_stamp(stp)
    );

    assign m_axis_tdata = {5'd0, stp, val, st};

    // A stalled result must not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Non-hit results never carry a stamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st != 3'(opdc_pkg::ST_HIT) |-> stp == '0)
        else $error("stamp on non-hit result");

    // Unknown and miss results carry a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (st == 3'(opdc_pkg::ST_UNKNOWN) ||
        st == 3'(opdc_pkg::ST_MISS)) |-> val == '0)
        else $error("value on unknown or miss");
endmodule
